// ===== rtl/wssm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssm_pkg
// shared sizes, codes and types of the windowed sample stats monitor
// ----------------------------------------------------------------------------
package wssm_pkg;

    localparam int SOURCES = 4;
    localparam int WINDOW  = 288;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 24;
    localparam int TEMP_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CNT_OUT_W = 9;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 120;

    localparam int SLOT_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MEM_D   = SOURCES * WINDOW;
    localparam int MEM_W   = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int SUM_W   = RATE_W + CNT_W;
    localparam int DCNT_W  = $clog2(SUM_W + 1);

    localparam logic [RATE_W-1:0] RATE_MIN_START = RATE_W'(9999990);
    localparam logic signed [TEMP_W-1:0] TEMP_MIN_START = TEMP_W'(9990);

    localparam logic [1:0] REG_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_TEMP_LIM  = 2'd1;
    localparam logic [1:0] REG_RATE_LIM  = 2'd2;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_READ,
        B_ACC,
        B_DIV,
        B_DONE
    } back_state_t;

    // one classified sample handed from front to back
    typedef struct packed {
        logic                     acc;
        logic                     full;
        logic                     hot;
        logic                     low;
        logic [SLOT_W-1:0]        slot;
        logic [IDX_W-1:0]         head;
        logic [CNT_W-1:0]         n;
        logic [RATE_W-1:0]        rate;
        logic signed [TEMP_W-1:0] temp;
    } job_t;

    typedef struct packed {
        logic                     accepted;
        logic                     table_full;
        logic [CNT_OUT_W-1:0]     sample_count;
        logic [RATE_W-1:0]        rate_max;
        logic [RATE_W-1:0]        rate_min;
        logic [RATE_W-1:0]        rate_mean;
        logic signed [TEMP_W-1:0] temp_max;
        logic signed [TEMP_W-1:0] temp_min;
        logic                     high_temp_alert;
        logic                     low_rate_alert;
    } res_t;

endpackage

// ===== rtl/wssm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssm_front
// source lookup, slot allocation, interval check and alerts
// ----------------------------------------------------------------------------
module wssm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [wssm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wssm_pkg::IN_W-1:0]     in_data,
    output logic                          job_push,
    output wssm_pkg::job_t                job,
    input  logic                          q_full
);

    logic [15:0]                        interval_reg;
    logic signed [wssm_pkg::TEMP_W-1:0] temp_lim_reg;
    logic [wssm_pkg::RATE_W-1:0]        rate_lim_reg;
    logic [wssm_pkg::TIME_W-1:0]        last_reg;
    logic [wssm_pkg::ADDR_W-1:0]        saddr_reg [wssm_pkg::SOURCES];
    logic [wssm_pkg::SOURCES-1:0]       used_reg;
    logic [wssm_pkg::IDX_W-1:0]         head_reg  [wssm_pkg::SOURCES];
    logic [wssm_pkg::CNT_W-1:0]         fill_reg  [wssm_pkg::SOURCES];

    logic [wssm_pkg::ADDR_W-1:0]        addr;
    logic [wssm_pkg::TIME_W-1:0]        now;
    logic [wssm_pkg::RATE_W-1:0]        rate;
    logic signed [wssm_pkg::TEMP_W-1:0] temp;
    logic                               hit, free, found, acc, take;
    logic [wssm_pkg::SLOT_W-1:0]        hit_slot, free_slot, slot;
    logic [wssm_pkg::IDX_W-1:0]         h, h_next;
    logic [wssm_pkg::CNT_W-1:0]         f_old, f_new;

    assign addr = in_data[31:0];
    assign now  = in_data[63:32];
    assign rate = in_data[87:64];
    assign temp = in_data[103:88];

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        hit = 1'b0;
        free = 1'b0;
        hit_slot = '0;
        free_slot = '0;
        for (int i = wssm_pkg::SOURCES - 1; i >= 0; i--)
        begin
            if (used_reg[i] && saddr_reg[i] == addr)
            begin
                hit = 1'b1;
                hit_slot = wssm_pkg::SLOT_W'(i);
            end
            if (!used_reg[i])
            begin
                free = 1'b1;
                free_slot = wssm_pkg::SLOT_W'(i);
            end
        end
        found = hit || free;
        slot  = hit ? hit_slot : free_slot;
        // a newly claimed slot starts with an empty ring
        h     = hit ? head_reg[slot] : '0;
        f_old = hit ? fill_reg[slot] : '0;
        acc   = found && ((now - last_reg) >= wssm_pkg::TIME_W'(interval_reg));
        h_next = (h == wssm_pkg::IDX_W'(wssm_pkg::WINDOW - 1)) ? '0 : h + 1'b1;
        f_new = (acc && f_old < wssm_pkg::CNT_W'(wssm_pkg::WINDOW)) ? f_old + 1'b1 : f_old;
    end

    always_comb
    begin
        job.acc  = acc;
        job.full = !found;
        job.hot  = acc && (temp > temp_lim_reg);
        job.low  = acc && (rate < rate_lim_reg);
        job.slot = slot;
        job.head = h;
        job.n    = found ? f_new : '0;
        job.rate = rate;
        job.temp = temp;
    end

    assign job_push = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd300;
            temp_lim_reg <= 16'sd800;
            rate_lim_reg <= '0;
            last_reg     <= '0;
            used_reg     <= '0;
            for (int i = 0; i < wssm_pkg::SOURCES; i++)
            begin
                saddr_reg[i] <= '0;
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    wssm_pkg::REG_INTERVAL: interval_reg <= cfg_data[15:0];
                    wssm_pkg::REG_TEMP_LIM: temp_lim_reg <= cfg_data[15:0];
                    wssm_pkg::REG_RATE_LIM: rate_lim_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take && found)
            begin
                used_reg[slot]  <= 1'b1;
                saddr_reg[slot] <= addr;
                fill_reg[slot]  <= f_new;
                head_reg[slot]  <= acc ? h_next : h;
                if (acc)
                    last_reg <= now;
            end
        end
    end

endmodule

// ===== rtl/wssm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssm_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module wssm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wssm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output wssm_pkg::job_t pop_job
);

    wssm_pkg::job_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_job = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= !wp_reg;
            if (pop && !empty)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

// ===== rtl/wssm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssm_back
// ring storage, window walk, mean divider and result register
// ----------------------------------------------------------------------------
module wssm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  wssm_pkg::job_t q_job,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output wssm_pkg::res_t res
);

    wssm_pkg::back_state_t state_reg, state_next;

    logic [wssm_pkg::RATE_W-1:0]        rate_mem [wssm_pkg::MEM_D];
    logic signed [wssm_pkg::TEMP_W-1:0] temp_mem [wssm_pkg::MEM_D];
    logic [wssm_pkg::RATE_W-1:0]        rd_rate_reg;
    logic signed [wssm_pkg::TEMP_W-1:0] rd_temp_reg;

    wssm_pkg::job_t                     job_reg;
    logic [wssm_pkg::CNT_W-1:0]         k_reg;
    logic [wssm_pkg::SUM_W-1:0]         quo_reg;
    logic [wssm_pkg::CNT_W:0]           rem_reg;
    logic [wssm_pkg::DCNT_W-1:0]        dcnt_reg;
    logic [wssm_pkg::RATE_W-1:0]        rmax_reg, rmin_reg;
    logic signed [wssm_pkg::TEMP_W-1:0] tmax_reg, tmin_reg;
    logic                               res_valid_reg;
    wssm_pkg::res_t                     res_reg;

    logic [wssm_pkg::MEM_W-1:0]         base, wr_addr, rd_addr;
    logic                               mem_we, mem_re, load_res, last_k;
    logic [wssm_pkg::CNT_W+1:0]         rem_sh;
    logic [wssm_pkg::CNT_W+1:0]         rem_diff;

    assign base    = wssm_pkg::MEM_W'(job_reg.slot * wssm_pkg::WINDOW);
    assign wr_addr = base + wssm_pkg::MEM_W'(job_reg.head);
    assign rd_addr = base + wssm_pkg::MEM_W'(k_reg);
    assign last_k  = (k_reg + 1'b1 == job_reg.n);
    assign rem_sh  = {rem_reg, quo_reg[wssm_pkg::SUM_W-1]};
    assign rem_diff = rem_sh - {2'b00, job_reg.n};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wssm_pkg::B_IDLE:  if (!q_empty) state_next = wssm_pkg::B_WRITE;
            wssm_pkg::B_WRITE: state_next = (job_reg.full || job_reg.n == '0) ?
                                            wssm_pkg::B_DONE : wssm_pkg::B_READ;
            wssm_pkg::B_READ:  state_next = wssm_pkg::B_ACC;
            wssm_pkg::B_ACC:   state_next = last_k ? wssm_pkg::B_DIV : wssm_pkg::B_READ;
            wssm_pkg::B_DIV:   if (dcnt_reg == wssm_pkg::DCNT_W'(wssm_pkg::SUM_W - 1))
                                   state_next = wssm_pkg::B_DONE;
            wssm_pkg::B_DONE:  if (!res_valid_reg || res_ready) state_next = wssm_pkg::B_IDLE;
            default:           state_next = wssm_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        load_res = 1'b0;
        case (state_reg)
            wssm_pkg::B_IDLE:  q_pop    = !q_empty;
            wssm_pkg::B_WRITE: mem_we   = job_reg.acc;
            wssm_pkg::B_READ:  mem_re   = 1'b1;
            wssm_pkg::B_DONE:  load_res = !res_valid_reg || res_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rate_mem[wr_addr] <= job_reg.rate;
            temp_mem[wr_addr] <= job_reg.temp;
        end
        if (mem_re)
        begin
            rd_rate_reg <= rate_mem[rd_addr];
            rd_temp_reg <= temp_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wssm_pkg::B_IDLE:
            begin
                job_reg  <= q_job;
                k_reg    <= '0;
                quo_reg  <= '0;
                rem_reg  <= '0;
                dcnt_reg <= '0;
                rmax_reg <= '0;
                rmin_reg <= wssm_pkg::RATE_MIN_START;
                tmax_reg <= '0;
                tmin_reg <= wssm_pkg::TEMP_MIN_START;
            end
            wssm_pkg::B_ACC:
            begin
                k_reg   <= k_reg + 1'b1;
                quo_reg <= quo_reg + wssm_pkg::SUM_W'(rd_rate_reg);
                if (rd_rate_reg > rmax_reg) rmax_reg <= rd_rate_reg;
                if (rd_rate_reg < rmin_reg) rmin_reg <= rd_rate_reg;
                if (rd_temp_reg > tmax_reg) tmax_reg <= rd_temp_reg;
                if (rd_temp_reg < tmin_reg) tmin_reg <= rd_temp_reg;
            end
            wssm_pkg::B_DIV:
            begin
                // restoring division, one quotient bit a cycle
                dcnt_reg <= dcnt_reg + 1'b1;
                if (!rem_diff[wssm_pkg::CNT_W+1])
                begin
                    rem_reg <= rem_diff[wssm_pkg::CNT_W:0];
                    quo_reg <= {quo_reg[wssm_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[wssm_pkg::CNT_W:0];
                    quo_reg <= {quo_reg[wssm_pkg::SUM_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (load_res)
        begin
            if (job_reg.full)
            begin
                res_reg.accepted        <= 1'b0;
                res_reg.table_full      <= 1'b1;
                res_reg.sample_count    <= '0;
                res_reg.rate_max        <= '0;
                res_reg.rate_min        <= '0;
                res_reg.rate_mean       <= '0;
                res_reg.temp_max        <= '0;
                res_reg.temp_min        <= '0;
                res_reg.high_temp_alert <= 1'b0;
                res_reg.low_rate_alert  <= 1'b0;
            end
            else
            begin
                res_reg.accepted        <= job_reg.acc;
                res_reg.table_full      <= 1'b0;
                res_reg.sample_count    <= wssm_pkg::CNT_OUT_W'(job_reg.n);
                res_reg.rate_max        <= rmax_reg;
                res_reg.rate_min        <= rmin_reg;
                res_reg.rate_mean       <= (job_reg.n == '0) ? '0 :
                                           quo_reg[wssm_pkg::RATE_W-1:0];
                res_reg.temp_max        <= tmax_reg;
                res_reg.temp_min        <= tmin_reg;
                res_reg.high_temp_alert <= job_reg.hot;
                res_reg.low_rate_alert  <= job_reg.low;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wssm_pkg::B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wssm_pkg::B_ACC |-> k_reg < job_reg.n)
        else $error("window walk ran past fill count");

    a_full_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.table_full |-> !res_reg.accepted)
        else $error("table full result marked accepted");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wssm_pkg::B_WRITE |-> job_reg.n <= wssm_pkg::CNT_W'(wssm_pkg::WINDOW))
        else $error("fill count beyond window");

endmodule

// ===== rtl/windowed_sample_stats_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sample_stats_monitor
// per-source sliding window min, max and mean of rate and temperature
// ----------------------------------------------------------------------------
// One sample at a time: the front looks up or claims a source slot and checks
// the shared interval in the cycle a word is taken, then the back writes the
// ring and walks the source's window, a read state and an accumulate state per
// stored entry through the registered ring memory, followed by a restoring
// divider for the mean. Samples that find an empty window, table-full ones
// included, skip the walk and the divider. Up to two words queue ahead of the
// back. Ring contents need no clearing.
module windowed_sample_stats_monitor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [wssm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // source_addr, time_s, rate_sample, temp_sample
    input  logic [wssm_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // accepted, table_full, sample_count, rate_max, rate_min, rate_mean,
    // temp_max, temp_min, high_temp_alert, low_rate_alert, zero pad
    output logic [wssm_pkg::OUT_W-1:0] m_tdata
);

    wssm_pkg::job_t push_job, pop_job;
    wssm_pkg::res_t res;
    logic           push, q_full, q_empty, pop;

    wssm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .job_push(push), .job(push_job), .q_full(q_full)
    );

    wssm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_job(push_job), .full(q_full),
        .pop(pop), .empty(q_empty), .pop_job(pop_job)
    );

    wssm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_job(pop_job), .q_pop(pop),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {3'b000, res.low_rate_alert, res.high_temp_alert, res.temp_min,
                      res.temp_max, res.rate_mean, res.rate_min, res.rate_max,
                      res.sample_count, res.table_full, res.accepted};

endmodule
